@@ hw/rtl/tag_pkg.sv @@
// Shared types and constants for the traffic address generator.
// Used by the controller, the datapath and the top level.
package tag_pkg;

   localparam int ADDR_W    = 48;
   localparam int BURST_W   = 13;
   localparam int BPM_W     = 32;
   localparam int STRIDE_W  = 24;
   localparam int AM_W      = 7;
   localparam int MASTER_W  = 6;
   localparam int ORD_W     = 32;
   localparam int TAG_W     = 33;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 48;
   localparam int DIV_CNT_W = 5;

   localparam logic [BURST_W-1:0] BURST_128 = 13'd128;
   localparam logic [BURST_W-1:0] BURST_256 = 13'd256;
   localparam logic [ADDR_W-1:0]  LINE_MASK = 48'd511;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MASTERS = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NEED_READ   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_STRIDE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_SCATTER = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FINISHED    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_READ_BASE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BURST        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BPM          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE       = 3'd7;

   localparam logic [1:0] PAT_PRIVATE = 2'd0;
   localparam logic [1:0] PAT_STRIDED = 2'd1;
   localparam logic [1:0] PAT_SHARED  = 2'd2;
   localparam logic [1:0] PAT_SCATTER = 2'd3;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;

   typedef struct packed {
      logic accept;
      logic div_init;
      logic div_step;
      logic mul;
      logic fin;
      logic eval;
      logic sum;
      logic emit;
   } tag_cmd_type;

   typedef struct packed {
      logic dirty;
      logic div_last;
      logic eval_ok;
      logic out_free;
   } tag_sts_type;

endpackage

@@ hw/rtl/tag_ctrl.sv @@
// Sequencer for the traffic address generator.
// Drives tag_dp through tag_pkg command and status structs.
module tag_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tag_pkg::tag_sts_type sts,
   output tag_pkg::tag_cmd_type cmd
);
   import tag_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_EVAL = 3'd4;
   localparam logic [2:0] S_SUM  = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.dirty) begin
                  cmd.div_init = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.eval_ok ? S_SUM : S_EMIT;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_eval_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> !sts.dirty)
      else $error("evaluation with stale derived config");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_MUL))
      else $error("divider left early");
   a_sum_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> (state_ff == S_EMIT))
      else $error("sum not followed by emit");
`endif

endmodule

@@ hw/rtl/tag_dp.sv @@
// Datapath of the traffic address generator: config registers, divider,
// derived spans, trace position, address arithmetic and the output register.
// Uses tag_pkg; sequenced by tag_ctrl.
module tag_dp #(
   parameter int MAX_MASTERS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tag_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tag_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                req_restart,
   input  tag_pkg::tag_cmd_type                cmd,
   output tag_pkg::tag_sts_type                sts,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [tag_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tag_pkg::MASTER_W-1:0]        rsp_master,
   output logic                                rsp_is_write,
   output logic [tag_pkg::ADDR_W-1:0]          rsp_address,
   output logic [tag_pkg::BURST_W-1:0]         rsp_size,
   output logic [tag_pkg::TAG_W-1:0]           rsp_trace_ordinal,
   output logic                                rsp_last
);
   import tag_pkg::*;

   logic [1:0]          pattern_ff;
   logic [1:0]          op_mode_ff;
   logic [ADDR_W-1:0]   read_base_ff;
   logic [ADDR_W-1:0]   write_base_ff;
   logic [BURST_W-1:0]  burst_ff;
   logic [BPM_W-1:0]    bpm_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [AM_W-1:0]     am_ff;
   logic                dirty_ff;

   logic [ORD_W-1:0]     div_num_ff;
   logic [BURST_W-1:0]   div_rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [BURST_W:0]     div_shift;
   logic                 div_ge;
   logic [BURST_W:0]     div_diff;

   logic [ORD_W-1:0]    count_ff;
   logic [ORD_W-1:0]    count_m1;
   logic [55:0]         span_prod;
   logic [ADDR_W-1:0]   span_prod_ff;

   logic [STATUS_W-1:0] err_ff;
   logic [ADDR_W-1:0]   span_sel_ff;
   logic [STRIDE_W-1:0] mult_ff;
   logic [STATUS_W-1:0] err_in;
   logic [ADDR_W-1:0]   span_sel_in;
   logic [STRIDE_W-1:0] mult_in;
   logic [ADDR_W-1:0]   span1_sum;
   logic [ADDR_W-1:0]   span1;
   logic [BPM_W:0]      bpm_sum;
   logic [ADDR_W-1:0]   span0;
   logic [7:0]          lpw_sum;
   logic [7:0]          lpw;

   logic [MASTER_W-1:0] mcnt_ff;
   logic [ORD_W-1:0]    ocnt_ff;
   logic                wpend_ff;
   logic                done_ff;

   logic                bound_out;
   logic [STATUS_W-1:0] eval_status;
   logic                mixed;
   logic                cur_wr;
   logic                final_ord;
   logic                last_master;
   logic [53:0]         t1_prod;
   logic [55:0]         t2_prod;

   logic [STATUS_W-1:0] stat_ff;
   logic [ADDR_W-1:0]   t1_ff;
   logic [ADDR_W-1:0]   t2_ff;
   logic [ADDR_W-1:0]   sum_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [MASTER_W-1:0] master_ff;
   logic                wr_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                last_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MASTER_W-1:0] rsp_master_ff;
   logic                rsp_is_write_ff;
   logic [ADDR_W-1:0]   rsp_address_ff;
   logic [BURST_W-1:0]  rsp_size_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic                rsp_last_ff;
   logic                out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= PAT_PRIVATE;
         op_mode_ff    <= OP_READ;
         read_base_ff  <= '0;
         write_base_ff <= '0;
         burst_ff      <= BURST_128;
         bpm_ff        <= 32'd4096;
         stride_ff     <= 24'd128;
         am_ff         <= 7'd1;
         dirty_ff      <= 1'b1;
      end else begin
         if (csr_we) begin
            dirty_ff <= 1'b1;
            unique case (csr_index)
               REG_PATTERN:    pattern_ff    <= csr_wdata[1:0];
               REG_OP_MODE:    op_mode_ff    <= csr_wdata[1:0];
               REG_READ_BASE:  read_base_ff  <= csr_wdata[ADDR_W-1:0];
               REG_WRITE_BASE: write_base_ff <= csr_wdata[ADDR_W-1:0];
               REG_BURST:      burst_ff      <= csr_wdata[BURST_W-1:0];
               REG_BPM:        bpm_ff        <= csr_wdata[BPM_W-1:0];
               REG_STRIDE:     stride_ff     <= csr_wdata[STRIDE_W-1:0];
               REG_ACTIVE:     am_ff         <= csr_wdata[AM_W-1:0];
               default:        dirty_ff      <= 1'b1;
            endcase
         end else if (cmd.fin) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // restoring divider: per-master byte total / burst, one quotient bit per cycle in the divide state
   assign div_shift = {div_rem_ff, div_num_ff[ORD_W-1]};
   assign div_ge    = (div_shift >= {1'b0, burst_ff});
   assign div_diff  = div_ge ? (div_shift - {1'b0, burst_ff}) : div_shift;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_num_ff <= bpm_ff;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[ORD_W-2:0], div_ge};
         div_rem_ff <= div_diff[BURST_W-1:0];
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
   end

   // derived spans
   assign count_m1  = div_num_ff - 32'd1;
   assign span_prod = count_m1 * stride_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         count_ff     <= div_num_ff;
         span_prod_ff <= span_prod[ADDR_W-1:0];
      end
   end

   assign span1_sum = span_prod_ff + {35'd0, burst_ff} + LINE_MASK;
   assign span1     = span1_sum & ~LINE_MASK;
   assign bpm_sum   = {1'b0, bpm_ff} + 33'd511;
   assign span0     = {15'd0, bpm_sum[BPM_W:9], 9'd0};
   assign lpw_sum   = {1'b0, am_ff} + ((burst_ff == BURST_128) ? 8'd3 : 8'd1);
   assign lpw       = (burst_ff == BURST_128) ? (lpw_sum >> 2) : (lpw_sum >> 1);

   always_comb begin
      if (am_ff == '0 || am_ff > AM_W'(MAX_MASTERS)) begin
         err_in = ST_BAD_MASTERS;
      end else if (burst_ff == '0 || bpm_ff == '0 || div_rem_ff != '0) begin
         err_in = ST_NOT_ALIGNED;
      end else if ((pattern_ff == PAT_SHARED || pattern_ff == PAT_SCATTER) &&
                   op_mode_ff != OP_READ) begin
         err_in = ST_NEED_READ;
      end else if (pattern_ff == PAT_SHARED && stride_ff == '0) begin
         err_in = ST_ZERO_STRIDE;
      end else if (pattern_ff == PAT_SCATTER && burst_ff != BURST_128 &&
                   burst_ff != BURST_256) begin
         err_in = ST_BAD_SCATTER;
      end else begin
         err_in = ST_OK;
      end
      unique case (pattern_ff)
         PAT_PRIVATE: begin
            span_sel_in = span0;
            mult_in     = {11'd0, burst_ff};
         end
         PAT_STRIDED: begin
            span_sel_in = span1;
            mult_in     = stride_ff;
         end
         PAT_SHARED: begin
            span_sel_in = '0;
            mult_in     = stride_ff;
         end
         PAT_SCATTER: begin
            span_sel_in = {35'd0, burst_ff};
            mult_in     = {7'd0, lpw, 9'd0};
         end
         default: begin
            span_sel_in = '0;
            mult_in     = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         err_ff      <= err_in;
         span_sel_ff <= span_sel_in;
         mult_ff     <= mult_in;
      end
   end

   // trace position and evaluation
   assign bound_out   = ({1'b0, mcnt_ff} >= am_ff) || (ocnt_ff >= count_ff);
   assign mixed       = op_mode_ff[1];
   assign cur_wr      = mixed ? wpend_ff : (op_mode_ff == OP_WRITE);
   assign final_ord   = ({1'b0, ocnt_ff} + 33'd1) == {1'b0, count_ff};
   assign last_master = ({1'b0, mcnt_ff} + 7'd1) == am_ff;
   assign t1_prod     = mcnt_ff * span_sel_ff;
   assign t2_prod     = ocnt_ff * mult_ff;

   always_comb begin
      if (err_ff != ST_OK) begin
         eval_status = err_ff;
      end else if (done_ff || bound_out) begin
         eval_status = ST_FINISHED;
      end else begin
         eval_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff  <= '0;
         ocnt_ff  <= '0;
         wpend_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else if (cmd.accept && req_restart) begin
         mcnt_ff  <= '0;
         ocnt_ff  <= '0;
         wpend_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else if (cmd.eval) begin
         if (err_ff == ST_OK && !done_ff && bound_out) begin
            done_ff <= 1'b1;
         end else if (eval_status == ST_OK) begin
            if (mixed && !cur_wr) begin
               wpend_ff <= 1'b1;
            end else begin
               wpend_ff <= 1'b0;
               if (final_ord && last_master) begin
                  done_ff <= 1'b1;
               end else if (final_ord) begin
                  ocnt_ff <= '0;
                  mcnt_ff <= mcnt_ff + 6'd1;
               end else begin
                  ocnt_ff <= ocnt_ff + 32'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         stat_ff   <= eval_status;
         t1_ff     <= t1_prod[ADDR_W-1:0];
         t2_ff     <= t2_prod[ADDR_W-1:0];
         base_ff   <= cur_wr ? write_base_ff : read_base_ff;
         master_ff <= mcnt_ff;
         wr_ff     <= cur_wr;
         tag_ff    <= mixed ? {ocnt_ff, cur_wr} : {1'b0, ocnt_ff};
         last_ff   <= !(mixed && !cur_wr) && final_ord && last_master;
      end
      if (cmd.sum) begin
         sum_ff <= t1_ff + t2_ff;
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= stat_ff;
         if (stat_ff == ST_OK) begin
            rsp_master_ff   <= master_ff;
            rsp_is_write_ff <= wr_ff;
            rsp_address_ff  <= sum_ff + base_ff;
            rsp_size_ff     <= burst_ff;
            rsp_tag_ff      <= tag_ff;
            rsp_last_ff     <= last_ff;
         end else begin
            rsp_master_ff   <= '0;
            rsp_is_write_ff <= 1'b0;
            rsp_address_ff  <= '0;
            rsp_size_ff     <= '0;
            rsp_tag_ff      <= '0;
            rsp_last_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_master        = rsp_master_ff;
   assign rsp_is_write      = rsp_is_write_ff;
   assign rsp_address       = rsp_address_ff;
   assign rsp_size          = rsp_size_ff;
   assign rsp_trace_ordinal = rsp_tag_ff;
   assign rsp_last          = rsp_last_ff;

   assign sts.dirty    = dirty_ff;
   assign sts.div_last = (div_cnt_ff == '1);
   assign sts.eval_ok  = (eval_status == ST_OK);
   assign sts.out_free = out_free;

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_master == '0 && rsp_address == '0 && rsp_size == '0 &&
       rsp_trace_ordinal == '0 && !rsp_last && !rsp_is_write))
      else $error("status beat carries payload");
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_status == ST_OK))
      else $error("last flag on a status beat");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output beat overwritten while stalled");
`endif

endmodule

@@ hw/rtl/traffic_address_generator_top.sv @@
// Traffic address generator: one bus transaction (or status beat) per request.
// Channels: req_* (restart flag), rsp_* (transaction), csr_* (config writes).
// Each request beat with req_valid high and req_stall low produces exactly one
// response beat. rsp_status is 0 for a transaction, 1..5 for a config error
// (payload zero, position held) and 6 once the trace is finished.
// A transaction passes through the evaluate, sum and emit states before its
// response is loaded, a status beat through evaluate and emit; the next request
// is taken once the controller is back in idle after the response is loaded.
// After reset and after any csr write, the next request first runs a 32-step
// shift-subtract divider (bytes per master / burst) and the multiply and finish
// span states before it is evaluated.
// Reset clears the trace position and restores register defaults. While
// rsp_stall is high the response beat holds; one further request may be
// accepted and worked on, and it waits in the datapath until the output frees.
// The user must write config only while no request is in flight; not enforced.
module traffic_address_generator_top #(
   parameter int MAX_MASTERS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tag_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tag_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tag_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tag_pkg::MASTER_W-1:0]        rsp_master,
   output logic                                rsp_is_write,
   output logic [tag_pkg::ADDR_W-1:0]          rsp_address,
   output logic [tag_pkg::BURST_W-1:0]         rsp_size,
   output logic [tag_pkg::TAG_W-1:0]           rsp_trace_ordinal,
   output logic                                rsp_last
);
   import tag_pkg::*;

   tag_cmd_type cmd;
   tag_sts_type sts;

   tag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tag_dp #(
      .MAX_MASTERS (MAX_MASTERS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_restart       (req_restart),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_master        (rsp_master),
      .rsp_is_write      (rsp_is_write),
      .rsp_address       (rsp_address),
      .rsp_size          (rsp_size),
      .rsp_trace_ordinal (rsp_trace_ordinal),
      .rsp_last          (rsp_last)
   );

endmodule

@@ tb/tag_trace_check.sv @@
// Checker for the traffic address generator: follows configuration writes, predicts one
// transaction or status beat per request beat and compares each response beat with it.
// Depends on tag_pkg for widths, status codes, register indexes and pattern codes.
module tag_trace_check #(
   parameter int MAX_MASTERS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tag_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_restart,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [tag_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [tag_pkg::MASTER_W-1:0]    rsp_master,
   input  logic                            rsp_is_write,
   input  logic [tag_pkg::ADDR_W-1:0]      rsp_address,
   input  logic [tag_pkg::BURST_W-1:0]     rsp_size,
   input  logic [tag_pkg::TAG_W-1:0]       rsp_trace_ordinal,
   input  logic                            rsp_last,
   output int                              mismatches,
   output int                              txns_due
);
   import tag_pkg::*;

   localparam logic [63:0] LINE_BYTES = 64'd512;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MASTER_W-1:0] master;
      logic                is_write;
      logic [ADDR_W-1:0]   address;
      logic [BURST_W-1:0]  size;
      logic [TAG_W-1:0]    ordinal;
      logic                last;
   } txn_beat_type;

   logic [1:0]          cfg_pattern;
   logic [1:0]          cfg_op;
   logic [ADDR_W-1:0]   cfg_rbase;
   logic [ADDR_W-1:0]   cfg_wbase;
   logic [BURST_W-1:0]  cfg_burst;
   logic [BPM_W-1:0]    cfg_bpm;
   logic [STRIDE_W-1:0] cfg_stride;
   logic [AM_W-1:0]     cfg_masters;

   logic [MASTER_W-1:0] pos_master;
   logic [ORD_W-1:0]    pos_ord;
   logic                wr_due;
   logic                trace_done;

   txn_beat_type due_txns[$];
   int fail_count = 0;

   assign mismatches = fail_count;

   task automatic flag_mismatch(string what);
      $display("[%0t] tag mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic logic [STATUS_W-1:0] config_status();
      if (cfg_masters == 0 || int'(cfg_masters) > MAX_MASTERS) return ST_BAD_MASTERS;
      if (cfg_burst == 0 || cfg_bpm == 0 || cfg_bpm % cfg_burst != 0) return ST_NOT_ALIGNED;
      if ((cfg_pattern == PAT_SHARED || cfg_pattern == PAT_SCATTER) && cfg_op != OP_READ)
         return ST_NEED_READ;
      if (cfg_pattern == PAT_SHARED && cfg_stride == 0) return ST_ZERO_STRIDE;
      if (cfg_pattern == PAT_SCATTER && cfg_burst != BURST_128 && cfg_burst != BURST_256)
         return ST_BAD_SCATTER;
      return ST_OK;
   endfunction

   function automatic logic [63:0] round_line(logic [63:0] v);
      return (v + LINE_BYTES - 1) & ~(LINE_BYTES - 1);
   endfunction

   function automatic logic [ADDR_W-1:0] txn_address(logic [63:0] m, logic [63:0] ord,
                                                     logic wr, logic [63:0] count);
      logic [63:0] base, rpl, lpw, addr;
      base = wr ? 64'(cfg_wbase) : 64'(cfg_rbase);
      case (cfg_pattern)
         PAT_SCATTER: begin
            rpl  = LINE_BYTES / cfg_burst;
            lpw  = (cfg_masters + rpl - 1) / rpl;
            addr = base + (ord * lpw + m / rpl) * LINE_BYTES + (m % rpl) * cfg_burst;
         end
         PAT_SHARED: addr = base + ord * cfg_stride;
         PAT_STRIDED: begin
            addr = base + m * round_line((count - 1) * cfg_stride + cfg_burst)
                   + ord * cfg_stride;
         end
         default: addr = base + m * round_line(64'(cfg_bpm)) + ord * cfg_burst;
      endcase
      return addr[ADDR_W-1:0];
   endfunction

   function automatic txn_beat_type trace_step(logic restart);
      txn_beat_type        b;
      logic [STATUS_W-1:0] st;
      logic [63:0]         count, m, ord;
      logic                mixed, wr;
      b = '0;
      if (restart) begin
         pos_master = '0;
         pos_ord    = '0;
         wr_due     = 1'b0;
         trace_done = 1'b0;
      end
      st = config_status();
      if (st != ST_OK) begin
         b.status = st;
         return b;
      end
      if (trace_done) begin
         b.status = ST_FINISHED;
         return b;
      end
      count = 64'(cfg_bpm / cfg_burst);
      if (64'(pos_master) >= 64'(cfg_masters) || 64'(pos_ord) >= count) begin
         trace_done = 1'b1;
         b.status   = ST_FINISHED;
         return b;
      end
      mixed = cfg_op[1];
      wr    = mixed ? wr_due : (cfg_op == OP_WRITE);
      m     = 64'(pos_master);
      ord   = 64'(pos_ord);
      b.master   = pos_master;
      b.is_write = wr;
      b.address  = txn_address(m, ord, wr, count);
      b.size     = cfg_burst;
      b.ordinal  = mixed ? TAG_W'(ord * 2 + 64'(wr)) : TAG_W'(ord);
      // hold the position until the write of this ordinal has gone out
      if (mixed && !wr) begin
         wr_due = 1'b1;
         return b;
      end
      wr_due = 1'b0;
      if (ord + 1 == count) begin
         if (m + 1 == 64'(cfg_masters)) begin
            trace_done = 1'b1;
            b.last     = 1'b1;
         end else begin
            pos_ord    = '0;
            pos_master = pos_master + 6'd1;
         end
      end else begin
         pos_ord = pos_ord + 32'd1;
      end
      return b;
   endfunction

   always @(posedge clock) begin : watch
      txn_beat_type want;
      txn_beat_type due;
      if (reset) begin
         cfg_pattern = PAT_PRIVATE;
         cfg_op      = OP_READ;
         cfg_rbase   = '0;
         cfg_wbase   = '0;
         cfg_burst   = BURST_128;
         cfg_bpm     = 32'd4096;
         cfg_stride  = 24'd128;
         cfg_masters = 7'd1;
         pos_master  = '0;
         pos_ord     = '0;
         wr_due      = 1'b0;
         trace_done  = 1'b0;
         due_txns.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_txns.size() == 0) begin
               flag_mismatch("response beat with no transaction due");
            end else begin
               want = due_txns.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("master", rsp_master, want.master);
               check_field("is_write", rsp_is_write, want.is_write);
               check_field("address", rsp_address, want.address);
               check_field("size", rsp_size, want.size);
               check_field("trace_ordinal", rsp_trace_ordinal, want.ordinal);
               check_field("last", rsp_last, want.last);
            end
         end
         if (req_valid && !req_stall) begin
            due = trace_step(req_restart);
            due_txns.insert(due_txns.size(), due);
         end
         if (csr_we) begin
            case (csr_index)
               REG_PATTERN:    cfg_pattern = csr_wdata[1:0];
               REG_OP_MODE:    cfg_op      = csr_wdata[1:0];
               REG_READ_BASE:  cfg_rbase   = csr_wdata[ADDR_W-1:0];
               REG_WRITE_BASE: cfg_wbase   = csr_wdata[ADDR_W-1:0];
               REG_BURST:      cfg_burst   = csr_wdata[BURST_W-1:0];
               REG_BPM:        cfg_bpm     = csr_wdata[BPM_W-1:0];
               REG_STRIDE:     cfg_stride  = csr_wdata[STRIDE_W-1:0];
               default:        cfg_masters = csr_wdata[AM_W-1:0];
            endcase
         end
      end
      txns_due <= due_txns.size();
   end

endmodule

@@ tb/traffic_address_generator_top_test.sv @@
// Testbench top for the traffic address generator: drives restart beats and register
// writes with random idling and back-pressure, and gives the verdict.
// Depends on tag_pkg, traffic_address_generator_top and the tag_trace_check checker.
module traffic_address_generator_top_test;
   import tag_pkg::*;

   localparam logic [1:0]        OP_MIXED     = 2'd2;
   localparam logic [1:0]        OP_MIXED_ALT = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
   localparam int                RANDOM_BEATS = 410;
   localparam int                HOLD_CYCLES  = 60;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = REG_PATTERN;
   logic [CSR_W-1:0]     csr_wdata   = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_restart = 1'b0;
   logic                 rsp_stall   = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [MASTER_W-1:0]  rsp_master;
   logic                 rsp_is_write;
   logic [ADDR_W-1:0]    rsp_address;
   logic [BURST_W-1:0]   rsp_size;
   logic [TAG_W-1:0]     rsp_trace_ordinal;
   logic                 rsp_last;
   int                   mismatches;
   int                   txns_due;

   int   idle_pct   = 0;
   int   stall_pct  = 0;
   logic hold_req   = 1'b0;
   int   beats_sent = 0;

   traffic_address_generator_top #(.MAX_MASTERS(64)) dut (.*);

   tag_trace_check #(.MAX_MASTERS(64)) trace_check (.*);

   always #1 clock = ~clock;

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic settle();
      req_valid <= 1'b0;
      while (txns_due != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [1:0] pat, input logic [1:0] op,
                              input logic [ADDR_W-1:0] rbase, input logic [ADDR_W-1:0] wbase,
                              input logic [BURST_W-1:0] burst, input logic [BPM_W-1:0] bpm,
                              input logic [STRIDE_W-1:0] stride,
                              input logic [AM_W-1:0] masters);
      settle();
      write_csr(REG_PATTERN, CSR_W'(pat));
      write_csr(REG_OP_MODE, CSR_W'(op));
      write_csr(REG_READ_BASE, CSR_W'(rbase));
      write_csr(REG_WRITE_BASE, CSR_W'(wbase));
      write_csr(REG_BURST, CSR_W'(burst));
      write_csr(REG_BPM, CSR_W'(bpm));
      write_csr(REG_STRIDE, CSR_W'(stride));
      write_csr(REG_ACTIVE, CSR_W'(masters));
      csr_we <= 1'b0;
   endtask

   task automatic send_beat(input logic restart);
      while ($urandom_range(99) < idle_pct) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   initial begin
      #2000000;
      $display("traffic_address_generator_top regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]          pat, op;
      logic [ADDR_W-1:0]   rbase, wbase;
      logic [BURST_W-1:0]  burst;
      logic [BPM_W-1:0]    bpm;
      logic [STRIDE_W-1:0] stride;
      logic [AM_W-1:0]     masters;
      int                  phase, n, first_random;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      send_beat(1'b1);
      send_beat(1'b0);
      send_beat(1'b0);

      // mixed strided trace over two masters, past its end
      load_config(PAT_STRIDED, OP_MIXED, ADDR_MAX, ADDR_MAX, 13'd256, 32'd512, '1, 7'd2);
      send_beat(1'b1);
      repeat (8) send_beat(1'b0);

      // drop a pending write by leaving mixed mode, then shrink the trace under the position
      load_config(PAT_PRIVATE, OP_MIXED_ALT, '0, 48'h1000, 13'd4096, 32'd8192, '0, 7'd64);
      send_beat(1'b1);
      load_config(PAT_PRIVATE, OP_READ, '0, 48'h1000, 13'd4096, 32'd8192, '0, 7'd64);
      send_beat(1'b0);
      load_config(PAT_PRIVATE, OP_READ, '0, 48'h1000, 13'd4096, 32'd4096, '0, 7'd64);
      send_beat(1'b0);

      // configuration errors, each kind at least once
      load_config(PAT_PRIVATE, OP_READ, '0, '0, BURST_128, 32'd4096, 24'd128, 7'd0);
      send_beat(1'b0);
      load_config(PAT_PRIVATE, OP_READ, '0, '0, BURST_128, 32'd4096, 24'd128, 7'd127);
      send_beat(1'b0);
      load_config(PAT_PRIVATE, OP_READ, '0, '0, 13'd0, 32'd4096, 24'd128, 7'd1);
      send_beat(1'b0);
      load_config(PAT_PRIVATE, OP_READ, '0, '0, BURST_128, 32'd0, 24'd128, 7'd1);
      send_beat(1'b0);
      load_config(PAT_STRIDED, OP_WRITE, '0, '0, 13'h1FFF, 32'hFFFF_FFFF, 24'd128, 7'd1);
      send_beat(1'b0);
      load_config(PAT_SHARED, OP_WRITE, '0, '0, BURST_128, 32'd4096, 24'd128, 7'd1);
      send_beat(1'b0);
      load_config(PAT_SHARED, OP_READ, '0, '0, BURST_128, 32'd4096, '0, 7'd1);
      send_beat(1'b0);
      load_config(PAT_SCATTER, OP_READ, '0, '0, 13'd512, 32'd4096, 24'd128, 7'd1);
      send_beat(1'b0);

      // scatter with every master and a zero stride
      load_config(PAT_SCATTER, OP_READ, ADDR_MAX, '0, BURST_128, 32'hFFFF_FF80, '0, 7'd64);
      send_beat(1'b1);
      send_beat(1'b0);

      first_random = beats_sent;
      phase = 0;
      while (beats_sent - first_random < RANDOM_BEATS) begin
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 55;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 55;
            end
            default: begin
               idle_pct  = 20;
               stall_pct = 20;
            end
         endcase

         pat = 2'($urandom_range(3));
         op  = (pat == PAT_SHARED || pat == PAT_SCATTER) ? OP_READ : 2'($urandom_range(3));
         if (pat == PAT_SCATTER) begin
            burst = $urandom_range(1) ? BURST_128 : BURST_256;
         end else begin
            case ($urandom_range(3))
               0:       burst = 13'd4096;
               1:       burst = 13'd1;
               default: burst = 13'($urandom_range(1, 4096));
            endcase
         end
         bpm = 32'(burst) * $urandom_range(1, 6);
         if ($urandom_range(15) == 0) bpm = 32'hFFFF_FFFF / 32'(burst) * 32'(burst);
         stride = ($urandom_range(3) == 0) ? '1 : 24'($urandom);
         if (pat != PAT_SHARED && $urandom_range(7) == 0) stride = '0;
         masters = $urandom_range(1) ? 7'($urandom_range(1, 4)) : 7'($urandom_range(1, 64));
         rbase = ($urandom_range(4) == 0) ? ADDR_MAX : ADDR_W'({$urandom, $urandom});
         wbase = ($urandom_range(4) == 0) ? '0 : ADDR_W'({$urandom, $urandom});
         // break the setup now and then
         if ($urandom_range(7) == 0) begin
            pat     = 2'($urandom);
            op      = 2'($urandom);
            burst   = 13'($urandom);
            bpm     = $urandom;
            masters = 7'($urandom);
         end
         load_config(pat, op, rbase, wbase, burst, bpm, stride, masters);

         if (phase % 5 == 2) hold_req = 1'b1;
         n = $urandom_range(8, 40);
         send_beat($urandom_range(9) != 0);
         repeat (n - 1) send_beat($urandom_range(24) == 0);
         phase++;
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("traffic_address_generator_top regression: pass");
      end else begin
         $display("traffic_address_generator_top regression: fail");
      end
      $finish;
   end

endmodule
